[hw/rtl/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg
// Types, codes and the operation schedule of the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int ELEMS      = 9;
	localparam int ADDR_BITS  = 4;
	localparam int DIGIT_BITS = 8;
	localparam int THR_BITS   = 31;
	localparam int OP_BITS    = 5;

	localparam logic [OP_BITS-1:0]   OP_LAST   = 5'd20;
	localparam logic [ADDR_BITS-1:0] LOAD_LAST = 4'd8;
	localparam logic [ADDR_BITS-1:0] ELEM_LAST = 4'd8;

	typedef enum logic [3:0] {
		S_LOAD,
		S_RDA,
		S_RDB,
		S_CAPB,
		S_MUL,
		S_FIN,
		S_CHK,
		S_DRD,
		S_DCAP,
		S_DPRE,
		S_DIV,
		S_EMIT,
		S_OUT
	} mi3_state_t;

	typedef enum logic [1:0] {
		M_LOAD,
		M_SUBWR,
		M_ACC,
		M_DET
	} mi3_mode_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] a_addr;
		logic [ADDR_BITS-1:0] b_addr;
		logic                 b_adj;
		mi3_mode_t            mode;
		logic [ADDR_BITS-1:0] dst;
	} mi3_op_t;

	function automatic mi3_op_t mk(input int a, input int b, input logic adj,
		input mi3_mode_t m, input int d);
		mi3_op_t o;
		o.a_addr = ADDR_BITS'(a);
		o.b_addr = ADDR_BITS'(b);
		o.b_adj  = adj;
		o.mode   = m;
		o.dst    = ADDR_BITS'(d);
		return o;
	endfunction

	// Even steps before 18 form the first product of a cofactor, odd ones subtract
	// the second and store the adjugate term; steps 18 to 20 form the determinant.
	function automatic mi3_op_t mi3_op(input logic [OP_BITS-1:0] idx);
		mi3_op_t o;
		case (idx)
			5'd0:  o = mk(4, 8, 1'b0, M_LOAD, 0);
			5'd1:  o = mk(5, 7, 1'b0, M_SUBWR, 0);
			5'd2:  o = mk(7, 2, 1'b0, M_LOAD, 1);
			5'd3:  o = mk(8, 1, 1'b0, M_SUBWR, 1);
			5'd4:  o = mk(1, 5, 1'b0, M_LOAD, 2);
			5'd5:  o = mk(2, 4, 1'b0, M_SUBWR, 2);
			5'd6:  o = mk(5, 6, 1'b0, M_LOAD, 3);
			5'd7:  o = mk(3, 8, 1'b0, M_SUBWR, 3);
			5'd8:  o = mk(8, 0, 1'b0, M_LOAD, 4);
			5'd9:  o = mk(6, 2, 1'b0, M_SUBWR, 4);
			5'd10: o = mk(2, 3, 1'b0, M_LOAD, 5);
			5'd11: o = mk(0, 5, 1'b0, M_SUBWR, 5);
			5'd12: o = mk(3, 7, 1'b0, M_LOAD, 6);
			5'd13: o = mk(4, 6, 1'b0, M_SUBWR, 6);
			5'd14: o = mk(6, 1, 1'b0, M_LOAD, 7);
			5'd15: o = mk(7, 0, 1'b0, M_SUBWR, 7);
			5'd16: o = mk(0, 4, 1'b0, M_LOAD, 8);
			5'd17: o = mk(1, 3, 1'b0, M_SUBWR, 8);
			5'd18: o = mk(0, 0, 1'b1, M_LOAD, 0);
			5'd19: o = mk(1, 3, 1'b1, M_ACC, 0);
			5'd20: o = mk(2, 6, 1'b1, M_DET, 0);
			default: o = mk(0, 0, 1'b0, M_LOAD, 0);
		endcase
		return o;
	endfunction

endpackage

[hw/rtl/matrix_inverse_3x3.sv]
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Loads a 3x3 fixed-point matrix and streams out its inverse by the adjugate.
//
//   channel   direction  handshake            beat
//   in        input      in_valid/in_stall    one matrix element, row-major
//   out       output     out_valid/out_stall  one inverse element or singular mark
//   cfg       input      cfg_valid/cfg_ready  det_threshold
//
// Each element is stored as it is accepted. After the ninth, 21 products run
// on one shared digit-serial multiplier, each over NSTEP digits (NSTEP = 9 by
// default), and then the determinant is checked. If it is singular, a singular
// mark follows. Otherwise every result runs through the restoring divider,
// which is skipped when the result is known to saturate before it runs.
// Inputs are stalled from the ninth beat until the last result beat is taken.
// A stalled output beat holds the sequencer. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [DATA_WIDTH-1:0] in_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_WIDTH-1:0] out_value,
	output logic                  invertible,
	output logic                  saturated,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [30:0]           cfg_data
);
	import mi3_pkg::*;

	localparam int W     = DATA_WIDTH;
	localparam int AW    = 2 * W + 1;
	localparam int DGT   = DIGIT_BITS;
	localparam int NSTEP = (AW + DGT - 1) / DGT;
	localparam int BP    = NSTEP * DGT;
	localparam int PW    = W + BP;
	localparam int DW    = 3 * W + 1;
	localparam int NW    = 4 * W + 2 * FRAC_BITS + 3;
	localparam int STW   = $clog2(NSTEP);
	localparam int DCW   = $clog2(W);

	mi3_state_t state_q, state_d;

	logic [ADDR_BITS-1:0] load_cnt_q;
	logic [OP_BITS-1:0]   op_q;
	logic [STW-1:0]       step_q;
	logic [ADDR_BITS-1:0] k_q;
	logic [DCW-1:0]       div_cnt_q;
	logic [THR_BITS-1:0]  thr_q;

	logic signed [W-1:0] a_q;
	logic [BP-1:0]       b_q;
	logic [PW-1:0]       acc_q;
	logic [DW-1:0]       hold_q;
	logic [DW-1:0]       det_q;
	logic [DW-1:0]       dabs_q;
	logic [NW-1:0]       rem_q;
	logic [NW-1:0]       dsh_q;
	logic [NW-1:0]       den_q;
	logic [W-1:0]        quo_q;
	logic                neg_q;
	logic                sat_q;

	logic [W-1:0] out_value_q;
	logic         invertible_q;
	logic         saturated_q;
	logic         last_q;

	mi3_op_t op;
	logic    in_acc, out_acc;

	logic          elem_we;
	logic [3:0]    elem_raddr;
	logic [W-1:0]  elem_rdata;
	logic          adj_we;
	logic [3:0]    adj_raddr;
	logic [AW-1:0] adj_wdata;
	logic [AW-1:0] adj_rdata;

	logic [DGT-1:0]        digit;
	logic signed [DGT:0]   dig_ext;
	logic signed [W+DGT:0] prod;
	logic [PW-1:0]         acc_next;

	logic [DW-1:0]  det_abs;
	logic [NW-1:0]  thr_ext;
	logic           singular;
	logic [AW-1:0]  adj_abs;
	logic [NW-1:0]  num;
	logic [NW-1:0]  den;
	logic           pre_sat;
	logic           div_ge;
	logic [W-1:0]   lim;
	logic           over;
	logic [W-1:0]   mag;

	assign op        = mi3_op(op_q);
	assign in_stall  = (state_q != S_LOAD);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);
	assign out_acc   = out_valid && !out_stall;
	assign cfg_ready = 1'b1;

	assign out_value  = out_value_q;
	assign invertible = invertible_q;
	assign saturated  = saturated_q;
	assign last       = last_q;

	assign elem_we    = in_acc;
	assign elem_raddr = (state_q == S_RDA) ? op.a_addr : op.b_addr;
	assign adj_we     = (state_q == S_FIN) && (op.mode == M_SUBWR);
	assign adj_wdata  = hold_q[AW-1:0] - acc_q[AW-1:0];
	assign adj_raddr  = (state_q == S_DRD) ? k_q : op.b_addr;

	mi3_ram #(.WIDTH(W), .DEPTH(ELEMS)) u_elem_ram (
		.clk   (clk),
		.we    (elem_we),
		.waddr (load_cnt_q),
		.wdata (in_value),
		.raddr (elem_raddr),
		.rdata (elem_rdata)
	);

	mi3_ram #(.WIDTH(AW), .DEPTH(ELEMS)) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (op.dst),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	// Most significant digit first; only the top digit carries the sign.
	assign digit    = b_q[BP-1 -: DGT];
	assign dig_ext  = (step_q == '0) ? {digit[DGT-1], digit} : {1'b0, digit};
	assign prod     = a_q * dig_ext;
	assign acc_next = (acc_q << DGT) + {{(BP-DGT-1){prod[W+DGT]}}, prod};

	assign det_abs  = det_q[DW-1] ? (~det_q + 1'b1) : det_q;
	assign thr_ext  = {{(NW-THR_BITS){1'b0}}, thr_q} << (2 * FRAC_BITS);
	assign singular = (det_abs == '0) || ({{(NW-DW){1'b0}}, det_abs} < thr_ext);

	assign adj_abs = adj_rdata[AW-1] ? (~adj_rdata + 1'b1) : adj_rdata;
	assign num     = ({{(NW-AW){1'b0}}, adj_abs} << (2 * FRAC_BITS + 1))
		+ {{(NW-DW){1'b0}}, dabs_q};
	assign den     = {{(NW-DW){1'b0}}, dabs_q} << 1;
	assign pre_sat = (rem_q >= (den_q << W));
	assign div_ge  = (rem_q >= dsh_q);

	assign lim  = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
	assign over = sat_q || (quo_q > lim);
	assign mag  = over ? lim : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				if (in_acc && (load_cnt_q == LOAD_LAST)) begin
					state_d = S_RDA;
				end
			end
			S_RDA:  state_d = S_RDB;
			S_RDB:  state_d = S_CAPB;
			S_CAPB: state_d = S_MUL;
			S_MUL: begin
				if (step_q == STW'(NSTEP - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN:  state_d = (op_q == OP_LAST) ? S_CHK : S_RDA;
			S_CHK:  state_d = singular ? S_OUT : S_DRD;
			S_DRD:  state_d = S_DCAP;
			S_DCAP: state_d = S_DPRE;
			S_DPRE: state_d = pre_sat ? S_EMIT : S_DIV;
			S_DIV: begin
				if (div_cnt_q == DCW'(W - 1)) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: state_d = S_OUT;
			S_OUT: begin
				if (out_acc) begin
					state_d = last_q ? S_LOAD : S_DRD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			op_q       <= '0;
			step_q     <= '0;
			k_q        <= '0;
			div_cnt_q  <= '0;
			thr_q      <= THR_BITS'(1);
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (in_acc) begin
				load_cnt_q <= (load_cnt_q == LOAD_LAST) ? '0 : load_cnt_q + 1'b1;
			end
			case (state_q)
				S_LOAD: begin
					op_q <= '0;
					k_q  <= '0;
				end
				S_CAPB: step_q <= '0;
				S_MUL:  step_q <= step_q + 1'b1;
				S_FIN:  op_q <= op_q + 1'b1;
				S_DPRE: div_cnt_q <= '0;
				S_DIV:  div_cnt_q <= div_cnt_q + 1'b1;
				S_OUT: begin
					if (out_acc) begin
						k_q <= k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_RDB: a_q <= elem_rdata;
			S_CAPB: begin
				acc_q <= '0;
				if (op.b_adj) begin
					b_q <= {{(BP-AW){adj_rdata[AW-1]}}, adj_rdata};
				end else begin
					b_q <= {{(BP-W){elem_rdata[W-1]}}, elem_rdata};
				end
			end
			S_MUL: begin
				acc_q <= acc_next;
				b_q   <= b_q << DGT;
			end
			S_FIN: begin
				case (op.mode)
					M_LOAD:  hold_q <= acc_q[DW-1:0];
					M_ACC:   hold_q <= hold_q + acc_q[DW-1:0];
					M_DET:   det_q  <= hold_q + acc_q[DW-1:0];
					default: ;
				endcase
			end
			S_CHK: begin
				dabs_q       <= det_abs;
				out_value_q  <= '0;
				invertible_q <= 1'b0;
				saturated_q  <= 1'b0;
				last_q       <= 1'b1;
			end
			S_DCAP: begin
				rem_q <= num;
				den_q <= den;
				dsh_q <= den << (W - 1);
				neg_q <= adj_rdata[AW-1] ^ det_q[DW-1];
			end
			S_DPRE: begin
				sat_q <= pre_sat;
				quo_q <= '0;
			end
			S_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[W-2:0], div_ge};
				dsh_q <= dsh_q >> 1;
			end
			S_EMIT: begin
				out_value_q  <= neg_q ? (~mag + 1'b1) : mag;
				invertible_q <= 1'b1;
				saturated_q  <= over;
				last_q       <= (k_q == ELEM_LAST);
			end
			default: ;
		endcase
	end

endmodule

[hw/rtl/mi3_ram.sv]
// ----------------------------------------------------------------------------
// mi3_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mi3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/mi3_checker.sv]
// ----------------------------------------------------------------------------
// mi3_checker
// Port-level checks on the output stream of the matrix inverse.
// ----------------------------------------------------------------------------
module mi3_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [DATA_WIDTH-1:0] out_value,
	input logic                  invertible,
	input logic                  saturated,
	input logic                  last
);

	// A singular mark is the only beat of its matrix.
	a_singular_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invertible |-> last)
		else $error("singular beat without last");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invertible |-> (out_value == '0) && !saturated)
		else $error("singular beat carries data");

	// No element is taken while results are pending.
	a_no_load_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open during output");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(last))
		else $error("stalled output beat changed");

endmodule

bind matrix_inverse_3x3 mi3_checker #(.DATA_WIDTH(DATA_WIDTH)) u_mi3_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_value  (out_value),
	.invertible (invertible),
	.saturated  (saturated),
	.last       (last)
);

[verif/matrix_inverse_3x3_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_chk
// Watches the element, inverse and threshold channels of the 3x3 inverse,
// loads its own copy of each matrix, works out the inverse beats exactly and
// compares every output beat with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] in_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] out_value,
	input  logic        invertible,
	input  logic        saturated,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [30:0] cfg_data,
	output int          fails,
	output int          pending
);

	typedef struct packed {
		logic [31:0] value;
		logic        inv;
		logic        sat;
		logic        last;
	} inv_beat_t;

	inv_beat_t          inverse_q[$];
	logic signed [31:0] matrix[9];
	int                 loaded;
	logic [30:0]        threshold;

	function automatic logic signed [127:0] cofactor(input int p, input int q,
		input int r, input int s);
		logic signed [127:0] a, b, c, d;
		a = matrix[p];
		b = matrix[q];
		c = matrix[r];
		d = matrix[s];
		return a * b - c * d;
	endfunction

	task automatic predict_inverse();
		logic signed [127:0] adj[9];
		logic signed [127:0] det, e0, e1, e2;
		logic [191:0]        dabs, num, quo, lim;
		logic                neg;
		inv_beat_t           b;
		adj[0] = cofactor(4, 8, 5, 7);
		adj[1] = cofactor(7, 2, 8, 1);
		adj[2] = cofactor(1, 5, 2, 4);
		adj[3] = cofactor(5, 6, 3, 8);
		adj[4] = cofactor(8, 0, 6, 2);
		adj[5] = cofactor(2, 3, 0, 5);
		adj[6] = cofactor(3, 7, 4, 6);
		adj[7] = cofactor(6, 1, 7, 0);
		adj[8] = cofactor(0, 4, 1, 3);
		e0 = matrix[0];
		e1 = matrix[1];
		e2 = matrix[2];
		det = e0 * adj[0] + e1 * adj[3] + e2 * adj[6];
		dabs = det < 0 ? 192'(-det) : 192'(det);
		if (dabs == 0 || dabs < (192'(threshold) << 32)) begin
			b = '{value: '0, inv: 1'b0, sat: 1'b0, last: 1'b1};
			inverse_q.push_back(b);
			return;
		end
		for (int k = 0; k < 9; k++) begin
			neg = (adj[k] < 0) != (det < 0);
			num = (adj[k] < 0 ? 192'(-adj[k]) : 192'(adj[k])) << 33;
			quo = (num + dabs) / (dabs << 1);
			lim = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
			b.sat = quo > lim;
			if (b.sat)
				quo = lim;
			b.value = neg ? 32'(-quo[31:0]) : quo[31:0];
			b.inv = 1'b1;
			b.last = k == 8;
			inverse_q.push_back(b);
		end
	endtask

	assign pending = inverse_q.size();

	always @(posedge clk or negedge arst_n) begin
		inv_beat_t exp_b;
		if (!arst_n) begin
			inverse_q.delete();
			loaded = 0;
			threshold = 31'd1;
			fails = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				threshold = cfg_data;
			if (in_valid && !in_stall) begin
				matrix[loaded] = in_value;
				loaded++;
				if (loaded == 9) begin
					loaded = 0;
					predict_inverse();
				end
			end
			if (out_valid && !out_stall) begin
				if (inverse_q.size() == 0) begin
					$display("%0t: unexpected beat value %h inv %b sat %b last %b", $time,
						out_value, invertible, saturated, last);
					fails++;
				end else begin
					exp_b = inverse_q.pop_front();
					if (exp_b.value !== out_value || exp_b.inv !== invertible
						|| exp_b.sat !== saturated || exp_b.last !== last) begin
						$display("%0t: mismatch expected %h/%b/%b/%b actual %h/%b/%b/%b",
							$time, exp_b.value, exp_b.inv, exp_b.sat, exp_b.last,
							out_value, invertible, saturated, last);
						fails++;
					end
				end
			end
		end
	end

endmodule

[verif/matrix_inverse_3x3_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_tb
// Feeds directed and random 3x3 matrices under several singularity
// thresholds, with random gaps and output back-pressure, and reports the
// verdict of the checker.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_tb;

	localparam int WATCH_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] in_value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] out_value;
	logic        invertible;
	logic        saturated;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [30:0] cfg_data;
	int          fails;
	int          pending;
	logic        no_gaps;
	logic        hold_req;
	int          idle_cycles;

	matrix_inverse_3x3 i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_value  (in_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_value (out_value),
		.invertible(invertible),
		.saturated (saturated),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	matrix_inverse_3x3_chk i_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic put_element(input logic [31:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_value <= v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic put_matrix(input logic [31:0] m[9]);
		for (int i = 0; i < 9; i++)
			put_element(m[i]);
	endtask

	task automatic write_threshold(input logic [30:0] v);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (30) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_element(input int kind);
		case (kind)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
			default: return 32'($signed($urandom_range(0, 32'h1FF)) - 32'sh100);
		endcase
	endfunction

	task automatic put_random_matrix();
		logic [31:0] m[9];
		int kind, shape;
		kind = $urandom_range(0, 2);
		shape = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++)
			m[i] = rand_element(kind);
		if (shape == 0) begin
			for (int i = 0; i < 3; i++)
				m[6 + i] = m[i];
		end else if (shape == 1) begin
			for (int i = 0; i < 9; i++)
				if (i % 4 != 0)
					m[i] = 32'($signed($urandom_range(0, 15)) - 8);
		end else if (shape == 2) begin
			for (int i = 0; i < 9; i++)
				m[i] = i % 4 == 0 ? 32'($urandom_range(1, 4)) : 32'h0;
		end
		put_matrix(m);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_req) begin
			out_stall <= 1'b1;
			repeat (1500) @(negedge clk);
			hold_req = 1'b0;
			out_stall <= 1'b0;
		end else if (no_gaps) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= pick_gap() != 0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("FAIL matrix_inverse_3x3");
			$finish;
		end
	end

	initial begin
		logic [31:0] m[9];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_value = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		out_stall = 1'b0;
		no_gaps = 1'b0;
		hold_req = 1'b0;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		m = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
		put_matrix(m);
		m = '{32'h7FFFFFFF, 32'h80000000, 0, 0, 32'h1, 0, 0, 0, 32'hFFFFFFFF};
		put_matrix(m);
		m = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h7FFFFFFF};
		put_matrix(m);

		write_threshold(31'd0);
		m = '{default: 32'h0};
		put_matrix(m);
		m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
		put_matrix(m);

		write_threshold(31'h7FFFFFFF);
		m = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
		put_matrix(m);
		m = '{32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF};
		put_matrix(m);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_threshold(31'd1);
				1: write_threshold(31'($urandom_range(0, 32'h1FFFF)));
				2: write_threshold(31'($urandom));
				3: write_threshold(31'd0);
				default: write_threshold(31'($urandom_range(0, 32'h100)));
			endcase
			for (int n = 0; n < 6; n++) begin
				no_gaps = $urandom_range(0, 3) == 0;
				if (ph == 1 && n == 2)
					hold_req = 1'b1;
				put_random_matrix();
			end
			if (ph == 2) begin
				in_valid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
		end
		no_gaps = 1'b0;
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("PASS matrix_inverse_3x3");
		else
			$display("FAIL matrix_inverse_3x3");
		$finish;
	end

endmodule
